// ===== sv/bpg_pkg.sv =====
package bpg_pkg;

    localparam int BLOCK_BYTES = 16;

    localparam logic [2:0] MODE_ZERO  = 3'd0;
    localparam logic [2:0] MODE_X923  = 3'd1;
    localparam logic [2:0] MODE_ISO   = 3'd2;
    localparam logic [2:0] MODE_PKCS7 = 3'd3;
    localparam logic [2:0] MODE_NONE  = 3'd4;

    localparam logic [7:0] ISO_MARK  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // element [i] is byte i of the block, byte 0 goes out first
    typedef logic [BLOCK_BYTES-1:0][7:0] store_t;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        final_block;
        logic        length_error;
    } result_t;

    // Keep the first tail bytes, fill the rest by mode.
    function automatic logic [127:0] build_block(
        input store_t     bytes,
        input logic [3:0] tail,
        input logic [2:0] mode
    );
        logic [127:0] blk;
        logic [4:0]   pad_len;
        logic [7:0]   b;
        pad_len = 5'd16 - {1'b0, tail};
        blk = '0;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (4'(i) < tail)
            begin
                b = bytes[i];
            end
            else
            begin
                unique case (mode)
                    MODE_X923:  b = (i == BLOCK_BYTES - 1) ? {3'b000, pad_len} : ZERO_BYTE;
                    MODE_ISO:   b = (4'(i) == tail) ? ISO_MARK : ZERO_BYTE;
                    MODE_PKCS7: b = {3'b000, pad_len};
                    default:    b = ZERO_BYTE;
                endcase
            end
            blk[127 - 8*i -: 8] = b;
        end
        return blk;
    endfunction

endpackage

// ===== sv/block_padding_generator.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// in       | sink      | in_valid / in_stall | data_byte, has_byte, is_last
// out      | source    | out_valid/out_stall | block_high, block_low, final_block,
//          |           |                     | length_error
// cfg      | sink      | cfg_we              | cfg_data (pad mode)
//
// One request per cycle while in_stall is low; each result is registered into
// the result queue and goes out once the results ahead of it are taken. A
// three-entry result queue follows the padding logic; in_stall rises while it
// holds two or more results, so a message that ends on an aligned block with padding (two results) raises in_stall.
// Reset empties the queue, clears the byte count and sets PKCS7 mode.
module block_padding_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] block_high,
    output logic [63:0] block_low,
    output logic        final_block,
    output logic        length_error
);
    import bpg_pkg::*;

    logic [2:0] mode_reg;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    store_t     store_reg;
    store_t     store_next;

    result_t    q_reg [3];
    result_t    q_next [3];
    logic [1:0] count_reg;
    logic [1:0] count_next;

    logic       accept;
    logic       pop;
    logic [2:0] mode;
    logic       padded;
    logic       full;
    logic [3:0] tail;
    logic       push_a;
    logic       push_b;
    result_t    res_a;
    result_t    res_b;
    logic [127:0] tail_blk;
    logic [127:0] pad_blk;
    logic [1:0] base;
    logic [1:0] base_b;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = count_reg[1];
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    assign block_high   = q_reg[0].block_high;
    assign block_low    = q_reg[0].block_low;
    assign final_block  = q_reg[0].final_block;
    assign length_error = q_reg[0].length_error;

    // unused codes act as no padding
    assign mode   = (mode_reg > MODE_NONE) ? MODE_NONE : mode_reg;
    assign padded = (mode == MODE_X923) || (mode == MODE_ISO) || (mode == MODE_PKCS7);
    assign full   = has_byte && (cnt_reg == 4'd15);
    assign tail   = has_byte ? (cnt_reg + 4'd1) : cnt_reg;

    always_comb
    begin
        store_next = store_reg;
        if (has_byte)
        begin
            store_next[cnt_reg] = data_byte;
        end
    end

    assign tail_blk = build_block(store_next, tail, mode);
    assign pad_blk  = build_block('0, 4'd0, mode);

    always_comb
    begin
        res_a = '0;
        res_b = '0;
        res_b.block_high  = pad_blk[127:64];
        res_b.block_low   = pad_blk[63:0];
        res_b.final_block = 1'b1;
        if (full)
        begin
            res_a.block_high  = {store_next[0], store_next[1], store_next[2], store_next[3],
                                 store_next[4], store_next[5], store_next[6], store_next[7]};
            res_a.block_low   = {store_next[8], store_next[9], store_next[10], store_next[11],
                                 store_next[12], store_next[13], store_next[14], store_next[15]};
            res_a.final_block = is_last && !padded;
        end
        else if (mode == MODE_NONE)
        begin
            // partial tail without padding: drop it and flag
            res_a.final_block  = 1'b1;
            res_a.length_error = 1'b1;
        end
        else
        begin
            res_a.block_high  = tail_blk[127:64];
            res_a.block_low   = tail_blk[63:0];
            res_a.final_block = 1'b1;
        end
    end

    always_comb
    begin
        push_a = 1'b0;
        push_b = 1'b0;
        if (accept)
        begin
            push_a = full || (is_last && ((mode != MODE_NONE) || (tail != 4'd0)));
            push_b = full && is_last && padded;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (has_byte)
            begin
                cnt_next = cnt_reg + 4'd1;
            end
            if (is_last)
            begin
                cnt_next = 4'd0;
            end
        end
    end

    assign base   = count_reg - {1'b0, pop};
    assign base_b = base + {1'b0, push_a};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q_next[k] = (pop && k < 2) ? q_reg[k + 1] : q_reg[k];
            if (push_a && base == 2'(k))
            begin
                q_next[k] = res_a;
            end
            if (push_b && base_b == 2'(k))
            begin
                q_next[k] = res_b;
            end
        end
        count_next = base + {1'b0, push_a} + {1'b0, push_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PKCS7;
            cnt_reg   <= 4'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            cnt_reg   <= cnt_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
        for (int k = 0; k < 3; k++)
        begin
            q_reg[k] <= q_next[k];
        end
    end

`ifndef SYNTHESIS
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last && full && padded |=> count_reg[1])
        else $error("aligned padded end did not queue two results");

    a_error_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> final_block && block_high == 64'd0 && block_low == 64'd0)
        else $error("length error result carries data");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> cnt_reg == 4'd0)
        else $error("byte count not cleared at message end");
`endif

endmodule

// ===== test/padding_checker.sv =====
`timescale 1ns / 1ps

module padding_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        final_block,
    input  logic        length_error,
    output int          fail_count,
    output int          pending
);
    import bpg_pkg::*;

    logic [7:0] held_bytes [BLOCK_BYTES];
    logic [3:0] held_count;
    logic [2:0] pad_mode_now;
    result_t    blocks_due [$];

    // Bytes below tail come from the held block, the rest is padding.
    function automatic logic [127:0] pad_block(input logic [4:0] tail, input logic [2:0] mode);
        logic [127:0] blk;
        logic [7:0]   pad_len;
        logic [7:0]   b;
        pad_len = 8'd16 - {3'b000, tail};
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            if (i < tail)
                b = held_bytes[i];
            else if (mode == MODE_PKCS7)
                b = pad_len;
            else if (mode == MODE_X923)
                b = (i == BLOCK_BYTES - 1) ? pad_len : ZERO_BYTE;
            else if (mode == MODE_ISO)
                b = (i == tail) ? ISO_MARK : ZERO_BYTE;
            else
                b = ZERO_BYTE;
            blk[127 - 8*i -: 8] = b;
        end
        return blk;
    endfunction

    function automatic void queue_block(input logic [127:0] blk, input logic fin,
                                        input logic err);
        result_t r;
        r.block_high   = blk[127:64];
        r.block_low    = blk[63:0];
        r.final_block  = fin;
        r.length_error = err;
        blocks_due.insert(blocks_due.size(), r);
    endfunction

    task automatic take_request(input logic [7:0] b, input logic h, input logic l);
        logic [2:0] m;
        logic       padded;
        logic       full;
        m      = (pad_mode_now > MODE_NONE) ? MODE_NONE : pad_mode_now;
        padded = (m == MODE_X923) || (m == MODE_ISO) || (m == MODE_PKCS7);
        full   = 1'b0;
        if (h)
        begin
            held_bytes[held_count] = b;
            if (held_count == 4'd15)
            begin
                queue_block(pad_block(5'd16, m), l && !padded, 1'b0);
                held_count = '0;
                full = 1'b1;
            end
            else
            begin
                held_count = held_count + 4'd1;
            end
        end
        if (l)
        begin
            if (full)
            begin
                // aligned end: padded modes owe a whole pad block
                if (padded)
                    queue_block(pad_block(5'd0, m), 1'b1, 1'b0);
            end
            else if (m == MODE_NONE)
            begin
                if (held_count != 0)
                    queue_block('0, 1'b1, 1'b1);
            end
            else
            begin
                queue_block(pad_block({1'b0, held_count}, m), 1'b1, 1'b0);
            end
            held_count = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            held_count   = '0;
            pad_mode_now = MODE_PKCS7;
            blocks_due.delete();
            fail_count   = 0;
        end
        else
        begin
            // compare first: a result never belongs to the request taken at this edge
            if (out_valid && !out_stall)
            begin
                got = {block_high, block_low, final_block, length_error};
                if (blocks_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected block: %h %h final %b error %b",
                                 got.block_high, got.block_low,
                                 got.final_block, got.length_error);
                    fail_count++;
                end
                else
                begin
                    want = blocks_due.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display({"block mismatch: expected %h %h final %b error %b,",
                                      " got %h %h final %b error %b"},
                                     want.block_high, want.block_low,
                                     want.final_block, want.length_error,
                                     got.block_high, got.block_low,
                                     got.final_block, got.length_error);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                take_request(data_byte, has_byte, is_last);
            if (cfg_we)
                pad_mode_now = cfg_data;
        end
        pending = blocks_due.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bpg_pkg::*;

    localparam logic [2:0] MODE_TOP_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        final_block;
    logic        length_error;
    int          fail_count;
    int          pending;

    bit sender_idle;
    bit receiver_idle;
    int holds_asked;
    int holds_done;
    int requests_sent;

    block_padding_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .block_high   (block_high),
        .block_low    (block_low),
        .final_block  (final_block),
        .length_error (length_error)
    );

    padding_checker padding_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .block_high   (block_high),
        .block_low    (block_low),
        .final_block  (final_block),
        .length_error (length_error),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stall per block, plus one long hold-off on request
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        forever
        begin
            wait_cycles = receiver_idle ? $urandom_range(0, 7) : 0;
            if (holds_done != holds_asked)
            begin
                holds_done++;
                wait_cycles = 80;
            end
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_request(input logic [7:0] b, input logic h, input logic l);
        int gap;
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= h;
        is_last   <= l;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    // drop valid, let every block come out, then allow the pipeline to settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(input logic [2:0] m);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_message(input int len, input bit bare_end);
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1, !bare_end && (i == len - 1));
        end
        if (bare_end || len == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic int random_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 15);
            4, 5:       return 16 * $urandom_range(1, 2);
            6:          return 0;
            default:    return $urandom_range(17, 47);
        endcase
    endfunction

    initial
    begin
        int phase;
        int count;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = '0;
        has_byte      = 1'b0;
        is_last       = 1'b0;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        holds_asked   = 0;
        holds_done    = 0;
        requests_sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset mode: aligned message with extreme bytes, then pad block
        for (int i = 0; i < 16; i++)
            send_request((i % 2) ? 8'hFF : 8'h00, 1'b1, i == 15);
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1);

        set_mode(MODE_NONE);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);

        set_mode(MODE_ZERO);
        send_request(8'hFF, 1'b0, 1'b1);

        set_mode(MODE_TOP_UNUSED);
        send_request(8'h80, 1'b1, 1'b1);

        requests_sent = 0;
        phase = 0;
        while (requests_sent < 1700)
        begin
            // walk every mode once, extremes included, then pick at random
            set_mode((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)));
            if (phase == 3)
            begin
                sender_idle = 1'b0;
                holds_asked++;
                for (int i = 0; i < 6; i++)
                    send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            end
            count = $urandom_range(4, 10);
            for (int n = 0; n < count && requests_sent < 1700; n++)
                send_message(random_length(), $urandom_range(0, 3) == 0);
            phase++;
        end

        drain();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
sv/bpg_pkg.sv
sv/block_padding_generator.sv
test/padding_checker.sv
test/tb.sv
